[hdl/cclt_pkg.sv]
// Shared types and constants for the changed channel level table.
// No dependencies; cclt_if, cclt_datapath, cclt_ctrl and the top level use this package.
package cclt_pkg;

  localparam int TABLE_DEPTH  = 32;
  localparam int NUM_CH_DEF   = 32;
  localparam int IDX_W        = 5;
  localparam int LVL_W        = 8;
  localparam int CHAN_W       = 8;
  localparam int DEV_CH_W     = 4;

  // Request codes carried in req_type
  localparam logic REQ_SET   = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch_req;   // capture the accepted request
    logic idx_clr;     // restart the scan at channel 0
    logic set_read;    // read the stored level of the set channel
    logic set_write;   // store the new level if it differs
    logic scan_issue;  // read a changed channel and drop its mark
    logic idx_inc;     // advance the scan
    logic emit;        // load the result register
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_flush;    // pending input beat is a flush
    logic in_chan_ok;  // pending input channel is in range
    logic mark_hit;    // scanned channel is marked changed
    logic idx_end;     // scan sits on the last channel
    logic slot_free;   // result register can take a beat
    logic last_hit;    // issued channel is the last changed one
  } dp_sts_t;

endpackage

[hdl/cclt_if.sv]
// Handshake channel interfaces for requests and results.
// Depends on cclt_pkg for field widths.
interface cclt_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [cclt_pkg::CHAN_W-1:0] channel_index;
  logic [cclt_pkg::LVL_W-1:0]  level_in;

  modport source (output valid, req_type, channel_index, level_in, input ready);
  modport sink   (input valid, req_type, channel_index, level_in, output ready);
endinterface

interface cclt_out_if;
  logic                          valid;
  logic                          ready;
  logic                          device_sel;
  logic [cclt_pkg::DEV_CH_W-1:0] device_channel;
  logic [cclt_pkg::LVL_W-1:0]    level_out;
  logic                          last_of_flush;

  modport source (output valid, device_sel, device_channel, level_out, last_of_flush,
                  input ready);
  modport sink   (input valid, device_sel, device_channel, level_out, last_of_flush,
                  output ready);
endinterface

[hdl/cclt_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module cclt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/cclt_datapath.sv]
// Datapath: level RAM with written bits, changed marks, scan index, result register.
// Depends on cclt_pkg and cclt_ram.
module cclt_datapath #(
  parameter int NUM_CHANNELS = cclt_pkg::NUM_CH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cclt_pkg::ctl_cmd_t           cmd,
  output cclt_pkg::dp_sts_t            sts,
  input  logic                         in_req_type,
  input  logic [cclt_pkg::CHAN_W-1:0]  in_channel_index,
  input  logic [cclt_pkg::LVL_W-1:0]   in_level_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_device_sel,
  output logic [cclt_pkg::DEV_CH_W-1:0] out_device_channel,
  output logic [cclt_pkg::LVL_W-1:0]   out_level_out,
  output logic                         out_last_of_flush
);
  import cclt_pkg::*;

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [CHAN_W-1:0]       chan_r;
  logic [LVL_W-1:0]        lvl_r;
  logic [IDX_W-1:0]        idx_r;
  logic [NUM_CHANNELS-1:0] mark_r;
  logic [NUM_CHANNELS-1:0] wrtn_r;
  logic                    rd_wrtn_r;
  logic                    last_r;
  logic                    out_valid_r;
  logic                    out_sel_r;
  logic [DEV_CH_W-1:0]     out_ch_r;
  logic [LVL_W-1:0]        out_lvl_r;
  logic                    out_last_r;

  logic [AW-1:0]           set_addr;
  logic [AW-1:0]           scan_addr;
  logic [AW-1:0]           rd_addr;
  logic                    rd_en;
  logic [LVL_W-1:0]        ram_rdata;
  logic [LVL_W-1:0]        rd_level;
  logic                    ram_we;
  logic [NUM_CHANNELS-1:0] marks_above;

  assign set_addr  = chan_r[AW-1:0];
  assign scan_addr = idx_r[AW-1:0];
  assign rd_en     = cmd.set_read | cmd.scan_issue;
  assign rd_addr   = cmd.set_read ? set_addr : scan_addr;

  // Unwritten entries read as zero
  assign rd_level = rd_wrtn_r ? ram_rdata : '0;
  assign ram_we   = cmd.set_write && (rd_level != lvl_r);

  cclt_ram #(
    .WIDTH (LVL_W),
    .DEPTH (NUM_CHANNELS),
    .AW    (AW)
  ) u_level_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (set_addr),
    .wdata (lvl_r),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign marks_above = mark_r >> ({1'b0, idx_r} + 6'd1);

  always_comb begin
    sts.in_flush   = (in_req_type == REQ_FLUSH);
    sts.in_chan_ok = ({1'b0, in_channel_index} < 9'(NUM_CHANNELS));
    sts.mark_hit   = mark_r[scan_addr];
    sts.idx_end    = (idx_r == IDX_W'(NUM_CHANNELS - 1));
    sts.slot_free  = !out_valid_r || out_ready;
    sts.last_hit   = last_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r      <= '0;
      wrtn_r      <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
      if (ram_we) begin
        mark_r[set_addr] <= 1'b1;
        wrtn_r[set_addr] <= 1'b1;
      end
      if (cmd.scan_issue) begin
        mark_r[scan_addr] <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      chan_r <= in_channel_index;
      lvl_r  <= in_level_in;
    end
    if (rd_en) begin
      rd_wrtn_r <= cmd.set_read ? wrtn_r[set_addr] : wrtn_r[scan_addr];
    end
    if (cmd.scan_issue) begin
      last_r <= ~|marks_above;
    end
    if (cmd.emit) begin
      out_sel_r  <= idx_r[IDX_W-1];
      out_ch_r   <= idx_r[DEV_CH_W-1:0];
      out_lvl_r  <= rd_level;
      out_last_r <= last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_device_sel     = out_sel_r;
  assign out_device_channel = out_ch_r;
  assign out_level_out      = out_lvl_r;
  assign out_last_of_flush  = out_last_r;

  a_emit_valid : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("result register not loaded after emit");

  a_write_marks : assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (mark_r[$past(set_addr)] && wrtn_r[$past(set_addr)]))
    else $error("level write left channel unmarked");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_lvl_r)))
    else $error("stalled result beat not held");

endmodule

[hdl/cclt_ctrl.sv]
// Controller: sequences set requests and flush scans over the datapath.
// Depends on cclt_pkg.
module cclt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cclt_pkg::dp_sts_t   sts,
  output cclt_pkg::ctl_cmd_t  cmd
);
  import cclt_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SRD   = 3'd1;
  localparam logic [2:0] ST_SCMP  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_SEMIT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          if (sts.in_flush) begin
            cmd.idx_clr = 1'b1;
            state_nxt   = ST_SCAN;
          end else if (sts.in_chan_ok) begin
            state_nxt = ST_SRD;
          end
        end
      end
      ST_SRD: begin
        cmd.set_read = 1'b1;
        state_nxt    = ST_SCMP;
      end
      ST_SCMP: begin
        cmd.set_write = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_SCAN: begin
        if (sts.mark_hit) begin
          if (sts.slot_free) begin
            cmd.scan_issue = 1'b1;
            state_nxt      = ST_SEMIT;
          end
        end else if (sts.idx_end) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_SEMIT: begin
        cmd.emit = 1'b1;
        if (sts.last_hit) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_set_seq : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRD) |=> (state_r == ST_SCMP))
    else $error("set read not followed by compare");

  a_issue_slot : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_issue |-> sts.slot_free)
    else $error("scan read issued with result register busy");

  a_emit_after_issue : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> $past(cmd.scan_issue))
    else $error("emit without a preceding scan read");

endmodule

[hdl/changed_channel_level_table_core.sv]
// Changed channel level table: top level joining controller and datapath.
// Set beat: accept, read, then compare/write; only the accept when the channel is out of range.
// Flush beat: accept, then a scan of each channel up to the last changed one (all channels when
// none changed), an emit for each changed channel, and any stall of the single result register.
// Reset (rst_n, synchronous): marks, written bits and controller clear at once; levels
// read as zero until written, so no clearing pass is needed.
module changed_channel_level_table_core #(
  parameter int NUM_CHANNELS = cclt_pkg::NUM_CH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cclt_in_if.sink    in_ch,
  cclt_out_if.source out_ch
);
  import cclt_pkg::*;

  // Command and status bundles between the two halves
  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // Controller: owns the input handshake and the scan/set sequence
  cclt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: level RAM, changed marks, scan index and the result register
  cclt_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_req_type        (in_ch.req_type),
    .in_channel_index   (in_ch.channel_index),
    .in_level_in        (in_ch.level_in),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_device_sel     (out_ch.device_sel),
    .out_device_channel (out_ch.device_channel),
    .out_level_out      (out_ch.level_out),
    .out_last_of_flush  (out_ch.last_of_flush)
  );

endmodule
